// File: sv/i2cm_pkg.sv
// Package for the I2C master byte sequencer: command codes, beat types,
// bus phase counts. Used by the input register, engine, top level and testbench.
package i2cm_pkg;

	// Active command codes; idle marks no sequence in progress
	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_STOP  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_IDLE  = 3'd4;

	// Phase counts per command
	localparam logic [4:0] START_PHASES = 5'd2;
	localparam logic [4:0] STOP_PHASES  = 5'd3;
	localparam logic [4:0] BYTE_PHASES  = 5'd18;
	// Phase index where data bits end and the acknowledge bit begins
	localparam logic [4:0] ACK_PHASE    = 5'd16;
	localparam logic [4:0] ACK_HIGH     = 5'd17;

	localparam logic [9:0] TPP_RESET    = 10'd50;

	// Input beat kinds
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [1:0] command;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_sample;
	} in_beat_t;

	function automatic logic [4:0] phase_total(input logic [2:0] cmd);
		logic [4:0] n;
		n = BYTE_PHASES;
		if (cmd == CMD_START) n = START_PHASES;
		else if (cmd == CMD_STOP) n = STOP_PHASES;
		return n;
	endfunction

endpackage

// File: sv/i2cm_in_reg.sv
// Input register of the I2C master byte sequencer: unpacks and holds one beat.
// Depends on i2cm_pkg.
module i2cm_in_reg
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // command[1:0], tx_byte[9:2], send_ack[10], sda_sample[11]
	input  logic        s_tuser,   // kind
	input  logic        take,
	output logic        valid_s1,
	output in_beat_t    beat_s1
);

	// Accept while empty or while the held beat moves on
	assign s_tready = !valid_s1 || take;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_s1.kind       <= s_tuser;
			beat_s1.command    <= s_tdata[1:0];
			beat_s1.tx_byte    <= s_tdata[9:2];
			beat_s1.send_ack   <= s_tdata[10];
			beat_s1.sda_sample <= s_tdata[11];
		end
	end

endmodule

// File: sv/i2cm_engine.sv
// Sequencer state and result register of the I2C master byte sequencer.
// Steps the bus state for one beat per cycle while the result slot is free or being drained. Depends on i2cm_pkg.
module i2cm_engine
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  in_beat_t    beat_s1,
	input  logic [9:0]  tpp,
	output logic        take,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);

	logic [2:0] cmd_q, cmd_d;
	logic [4:0] phase_q, phase_d;
	logic [9:0] tick_q, tick_d;
	logic [7:0] shift_q, shift_d;
	logic       ackc_q, ackc_d;
	logic [7:0] rx_q, rx_d;
	logic       nack_q, nack_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       done_d, rej_d;
	logic [10:0] tick_inc;

	// Move a beat whenever the result slot is free or being drained
	assign take = valid_s1 && (!m_tvalid || m_tready);
	assign tick_inc = {1'b0, tick_q} + 11'd1;

	// Next state for the held beat
	always_comb begin
		logic [2:0] ec;
		logic [4:0] ep;
		logic       enter;
		cmd_d = cmd_q; phase_d = phase_q; tick_d = tick_q; shift_d = shift_q;
		ackc_d = ackc_q; rx_d = rx_q; nack_d = nack_q; scl_d = scl_q; sda_d = sda_q;
		done_d = 1'b0; rej_d = 1'b0;
		enter = 1'b0;
		ec = cmd_q;
		ep = phase_q;
		if (beat_s1.kind == KIND_CMD) begin
			if (cmd_q != CMD_IDLE) begin
				rej_d = 1'b1;
			end else begin
				ec = {1'b0, beat_s1.command};
				ep = 5'd0;
				cmd_d = ec;
				phase_d = 5'd0;
				tick_d = 10'd0;
				if (ec == CMD_WRITE) shift_d = beat_s1.tx_byte;
				else if (ec == CMD_READ) shift_d = 8'd0;
				if (ec == CMD_READ) ackc_d = beat_s1.send_ack;
				enter = 1'b1;
			end
		end else if (cmd_q != CMD_IDLE) begin
			if (tick_inc >= {1'b0, tpp}) begin
				tick_d = 10'd0;
				// Sample at the end of the phase
				if (cmd_q == CMD_WRITE) begin
					if (phase_q < ACK_PHASE && phase_q[0]) shift_d = {shift_q[6:0], 1'b0};
					else if (phase_q == ACK_HIGH) nack_d = beat_s1.sda_sample;
				end else if (cmd_q == CMD_READ) begin
					if (phase_q < ACK_PHASE && phase_q[0])
						shift_d = {shift_q[6:0], beat_s1.sda_sample};
				end
				ep = phase_q + 5'd1;
				if (ep >= phase_total(cmd_q)) begin
					// Finish the command
					if (cmd_q == CMD_START || cmd_q == CMD_WRITE) begin
						scl_d = 1'b0;
					end else if (cmd_q == CMD_READ) begin
						scl_d = 1'b0;
						rx_d = shift_d;
					end
					cmd_d = CMD_IDLE;
					phase_d = 5'd0;
					done_d = 1'b1;
				end else begin
					phase_d = ep;
					enter = 1'b1;
				end
			end else begin
				tick_d = tick_inc[9:0];
			end
		end
		// Set line levels on entry to a phase
		if (enter) begin
			unique case (ec)
				CMD_START: begin
					scl_d = 1'b1;
					sda_d = (ep == 5'd0);
				end
				CMD_STOP: begin
					scl_d = (ep != 5'd0);
					sda_d = (ep == 5'd2);
				end
				CMD_WRITE: begin
					if (ep[0]) begin
						scl_d = 1'b1;
					end else begin
						scl_d = 1'b0;
						sda_d = (ep < ACK_PHASE) ? shift_d[7] : 1'b1;
					end
				end
				CMD_READ: begin
					if (ep[0]) begin
						scl_d = 1'b1;
					end else begin
						scl_d = 1'b0;
						sda_d = (ep < ACK_PHASE) ? 1'b1 : !ackc_d;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance sequencer state on each moved beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_IDLE;
			phase_q <= 5'd0;
			tick_q <= 10'd0;
			shift_q <= 8'd0;
			ackc_q <= 1'b0;
			rx_q <= 8'd0;
			nack_q <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
		end else if (take) begin
			cmd_q <= cmd_d;
			phase_q <= phase_d;
			tick_q <= tick_d;
			shift_q <= shift_d;
			ackc_q <= ackc_d;
			rx_q <= rx_d;
			nack_q <= nack_d;
			scl_q <= scl_d;
			sda_q <= sda_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata <= {2'b00, rej_d, nack_d, rx_d, done_d, (cmd_d != CMD_IDLE), sda_d, scl_d};
		end
	end

endmodule

// File: sv/i2c_master_byte_sequencer.sv
// Top level of the I2C master byte sequencer: config register, input
// register and sequencer engine. Depends on i2cm_pkg, i2cm_in_reg, i2cm_engine.
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------
//  s_*      | in        | tuser kind; tdata command, tx_byte, send_ack, sda
//  m_*      | out       | tdata scl, sda, busy, done, rx_byte, nack, rejected
//  cfg_*    | in        | ticks_per_phase, written when cfg_wen is high
//
// One result beat per input beat; a beat is taken every cycle while no stall on m_tready holds the result.
// Each beat passes through the input register, then the sequencer step into the
// result register.
// Reset releases both lines, goes idle and sets ticks_per_phase to 50.
// A stall on m_tready holds the result; one more beat waits in the input register.
module i2c_master_byte_sequencer
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // command[1:0], tx_byte[9:2], send_ack[10], sda_sample[11]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // scl[0], sda[1], busy[2], done[3], rx_byte[11:4],
	                               // nack_seen[12], rejected[13]
	input  logic        cfg_wen,
	input  logic [9:0]  cfg_wdata
);

	logic [9:0] tpp_q;
	logic       valid_s1;
	in_beat_t   beat_s1;
	logic       take;

	// Hold ticks_per_phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpp_q <= TPP_RESET;
		end else if (cfg_wen) begin
			tpp_q <= cfg_wdata;
		end
	end

	i2cm_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (take),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	i2cm_engine u_eng (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.tpp      (tpp_q),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: sv/i2cm_checker.sv
// Port-level checks for the I2C master byte sequencer, bound to the top level.
// Depends only on the top-level ports.
module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// Stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed under stall");

	// A finishing beat leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done with busy set");

	// A rejected command means a sequence is still running
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tdata[2] && !m_tdata[3])
		else $error("rejected while idle or finishing");

endmodule

bind i2c_master_byte_sequencer i2cm_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/sv/i2c_master_byte_sequencer_tb.sv
// Self-checking testbench for i2c_master_byte_sequencer: a directed table, then
// random bus command sequences, each result beat checked against the table or a line-level model.
// Depends on i2cm_pkg and the i2c_master_byte_sequencer RTL.
module i2c_master_byte_sequencer_tb
	import i2cm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT  = 1000;
	localparam int TAIL_CYCLES = 10;

	// Result beat fields, scl in the lowest bit, matching m_tdata[13:0]
	typedef struct packed {
		logic       rej;
		logic       nack;
		logic [7:0] rx;
		logic       done;
		logic       busy;
		logic       sda;
		logic       scl;
	} line_res_t;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_op_t;

	typedef struct packed {
		row_op_t    op;
		in_beat_t   beat;
		logic [11:0] reps;
		logic       typed;
		line_res_t  want;
		logic [9:0] cfg;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // command[1:0], tx_byte[9:2], send_ack[10], sda_sample[11]
	logic        s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // scl[0], sda[1], busy[2], done[3], rx_byte[11:4],
	                        // nack_seen[12], rejected[13]
	logic        cfg_wen;
	logic [9:0]  cfg_wdata;

	// Line model state
	logic [9:0] tpp;
	logic [2:0] cur_cmd;
	logic [4:0] phase;
	logic [9:0] tcount;
	logic [7:0] shreg;
	logic       ack_sel;
	logic [7:0] rx_last;
	logic       nack_last;
	logic       scl_q;
	logic       sda_q;

	line_res_t line_res_q[$];
	dir_row_t  dir_q[$];
	int        err_cnt = 0;
	bit        in_calm = 1'b0;
	bit        out_calm = 1'b0;
	int        idle_cnt = 0;

	i2c_master_byte_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic logic [4:0] phase_count(input logic [2:0] cmd);
		case (cmd)
			CMD_START: return START_PHASES;
			CMD_STOP:  return STOP_PHASES;
			default:   return BYTE_PHASES;
		endcase
	endfunction

	// Set line levels on entry to the current phase
	function automatic void drive_phase();
		case (cur_cmd) inside
			CMD_START: begin
				scl_q = 1'b1;
				sda_q = (phase == 5'd0);
			end
			CMD_STOP: begin
				scl_q = (phase != 5'd0);
				sda_q = (phase == STOP_PHASES - 5'd1);
			end
			CMD_WRITE, CMD_READ: begin
				if (phase[0]) begin
					scl_q = 1'b1;
				end else begin
					scl_q = 1'b0;
					if (phase >= ACK_PHASE)
						sda_q = (cur_cmd == CMD_WRITE) ? 1'b1 : ~ack_sel;
					else
						sda_q = (cur_cmd == CMD_WRITE) ? shreg[7] : 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// Sample SDA at the end of a phase: shift data on high phases, catch the ack
	function automatic void close_phase(input logic sda_in);
		if (cur_cmd == CMD_WRITE) begin
			if (phase < ACK_PHASE && phase[0])
				shreg = {shreg[6:0], 1'b0};
			else if (phase == ACK_HIGH)
				nack_last = sda_in;
		end else if (cur_cmd == CMD_READ) begin
			if (phase < ACK_PHASE && phase[0])
				shreg = {shreg[6:0], sda_in};
		end
	endfunction

	// Advance the model by one input beat and return its result beat
	function automatic line_res_t i2c_step(input in_beat_t b);
		line_res_t  r;
		logic [10:0] nxt;
		r = '0;
		if (b.kind == KIND_CMD) begin
			if (cur_cmd != CMD_IDLE) begin
				r.rej = 1'b1;
			end else begin
				cur_cmd = {1'b0, b.command};
				phase = '0;
				tcount = '0;
				if (cur_cmd == CMD_WRITE) begin
					shreg = b.tx_byte;
				end else if (cur_cmd == CMD_READ) begin
					shreg = '0;
					ack_sel = b.send_ack;
				end
				drive_phase();
			end
		end else if (cur_cmd != CMD_IDLE) begin
			nxt = {1'b0, tcount} + 11'd1;
			// A zero setting ends every phase on each tick
			if (nxt >= {1'b0, tpp}) begin
				tcount = '0;
				close_phase(b.sda_sample);
				phase = phase + 5'd1;
				if (phase >= phase_count(cur_cmd)) begin
					if (cur_cmd != CMD_STOP)
						scl_q = 1'b0;
					if (cur_cmd == CMD_READ)
						rx_last = shreg;
					cur_cmd = CMD_IDLE;
					phase = '0;
					r.done = 1'b1;
				end else begin
					drive_phase();
				end
			end else begin
				tcount = nxt[9:0];
			end
		end
		r.scl  = scl_q;
		r.sda  = sda_q;
		r.busy = (cur_cmd != CMD_IDLE);
		r.rx   = rx_last;
		r.nack = nack_last;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = ~calm;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic in_beat_t rand_beat(input logic kind);
		in_beat_t b;
		b.kind       = kind;
		b.command    = 2'($urandom_range(0, 3));
		b.tx_byte    = 8'($urandom_range(0, 255));
		b.send_ack   = 1'($urandom_range(0, 1));
		b.sda_sample = 1'($urandom_range(0, 1));
		return b;
	endfunction

	function automatic line_res_t res(input logic scl, input logic sda, input logic busy,
			input logic done, input logic [7:0] rx, input logic nack, input logic rej);
		line_res_t r;
		r.scl  = scl;
		r.sda  = sda;
		r.busy = busy;
		r.done = done;
		r.rx   = rx;
		r.nack = nack;
		r.rej  = rej;
		return r;
	endfunction

	function automatic dir_row_t beat_row(input logic kind, input logic [2:0] cmd,
			input logic [7:0] tx, input logic ack, input logic sda, input int reps,
			input logic typed, input line_res_t want);
		dir_row_t row;
		row = '0;
		row.op              = ROW_BEAT;
		row.beat.kind       = kind;
		row.beat.command    = cmd[1:0];
		row.beat.tx_byte    = tx;
		row.beat.send_ack   = ack;
		row.beat.sda_sample = sda;
		row.reps            = 12'(reps);
		row.typed           = typed;
		row.want            = want;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [9:0] v);
		dir_row_t row;
		row = '0;
		row.op  = ROW_CFG;
		row.cfg = v;
		return row;
	endfunction

	// Present one beat after a random gap; queue its result once it is taken
	task automatic send_beat(input in_beat_t b, input logic typed, input line_res_t want);
		int        gap;
		line_res_t r;
		gap = draw_gap(in_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= b.kind;
		s_tdata  <= {4'b0, b.sda_sample, b.send_ack, b.tx_byte, b.command};
		do @(posedge clk); while (!s_tready);
		r = i2c_step(b);
		line_res_q.push_back(typed ? want : r);
	endtask

	// Finish any open sequence, drain results, then write ticks_per_phase
	task automatic write_ticks(input logic [9:0] v);
		while (cur_cmd != CMD_IDLE)
			send_beat(rand_beat(KIND_TICK), 1'b0, '0);
		s_tvalid <= 1'b0;
		while (line_res_q.size() != 0) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tpp = v;
	endtask

	// Mostly whole commands with their ticks; some cut short, some stray commands
	task automatic run_traffic(input int budget);
		int       used;
		int       n;
		in_beat_t b;
		used = 0;
		while (used < budget) begin
			b = rand_beat(KIND_CMD);
			send_beat(b, 1'b0, '0);
			used++;
			n = int'(phase_count({1'b0, b.command})) * ((tpp == 0) ? 1 : int'(tpp));
			if ($urandom_range(0, 7) == 0)
				n = $urandom_range(0, n);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 29) == 0)
					send_beat(rand_beat(KIND_CMD), 1'b0, '0);
				send_beat(rand_beat(KIND_TICK), 1'b0, '0);
				used++;
			end
			repeat ($urandom_range(0, 2))
				send_beat(rand_beat(KIND_TICK), 1'b0, '0);
		end
	endtask

	initial begin : stim_side
		in_beat_t sb;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;

		tpp       = TPP_RESET;
		cur_cmd   = CMD_IDLE;
		phase     = '0;
		tcount    = '0;
		shreg     = '0;
		ack_sel   = 1'b0;
		rx_last   = '0;
		nack_last = 1'b0;
		scl_q     = 1'b1;
		sda_q     = 1'b1;

		// Reset setting: idle tick, start, command while busy, full start timing
		dir_q.push_back(beat_row(KIND_TICK, CMD_STOP, 8'h00, 1'b0, 1'b1, 1, 1'b1,
			res(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)));
		dir_q.push_back(beat_row(KIND_CMD, CMD_START, 8'hFF, 1'b1, 1'b0, 1, 1'b1,
			res(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)));
		dir_q.push_back(beat_row(KIND_CMD, CMD_READ, 8'hA5, 1'b1, 1'b1, 1, 1'b1,
			res(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1)));
		dir_q.push_back(beat_row(KIND_TICK, CMD_START, 8'h00, 1'b0, 1'b1,
			2 * TPP_RESET - 1, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_START, 8'h00, 1'b0, 1'b0, 1, 1'b1,
			res(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0)));
		// One tick per phase: write all ones with a NACK, then all zeros with an ACK
		dir_q.push_back(cfg_row(10'd1));
		dir_q.push_back(beat_row(KIND_CMD, CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1, 1'b1,
			res(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)));
		dir_q.push_back(beat_row(KIND_TICK, CMD_WRITE, 8'h00, 1'b0, 1'b0, 17, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_WRITE, 8'h00, 1'b0, 1'b1, 1, 1'b1,
			res(1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0)));
		dir_q.push_back(beat_row(KIND_CMD, CMD_WRITE, 8'h00, 1'b1, 1'b1, 1, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_WRITE, 8'hFF, 1'b1, 1'b0, 18, 1'b0, '0));
		// Zero setting acts as one: read all ones with ACK, all zeros with NACK, stop
		dir_q.push_back(cfg_row(10'd0));
		dir_q.push_back(beat_row(KIND_CMD, CMD_READ, 8'h00, 1'b1, 1'b0, 1, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_READ, 8'h00, 1'b0, 1'b1, 17, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_READ, 8'h00, 1'b0, 1'b1, 1, 1'b1,
			res(1'b0, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0)));
		dir_q.push_back(beat_row(KIND_CMD, CMD_READ, 8'h00, 1'b0, 1'b1, 1, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_READ, 8'h00, 1'b0, 1'b0, 17, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_READ, 8'h00, 1'b0, 1'b0, 1, 1'b1,
			res(1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0)));
		dir_q.push_back(beat_row(KIND_CMD, CMD_STOP, 8'h00, 1'b0, 1'b0, 1, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_STOP, 8'h00, 1'b0, 1'b0, 2, 1'b0, '0));
		dir_q.push_back(beat_row(KIND_TICK, CMD_STOP, 8'h00, 1'b0, 1'b0, 1, 1'b1,
			res(1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0)));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_q[i]) begin
			if (dir_q[i].op == ROW_CFG)
				write_ticks(dir_q[i].cfg);
			else
				repeat (dir_q[i].reps) send_beat(dir_q[i].beat, dir_q[i].typed, dir_q[i].want);
		end

		// Random sequences over several phase lengths
		write_ticks(10'd1);
		run_traffic(200);
		write_ticks(10'd2);
		run_traffic(150);
		write_ticks(10'd0);
		run_traffic(100);
		write_ticks(10'($urandom_range(3, 6)));
		run_traffic(150);
		write_ticks(10'd1);
		run_traffic(100);

		// Longest phase: a start holds its first phase over many ticks
		write_ticks(10'd1023);
		sb = rand_beat(KIND_CMD);
		sb.command = CMD_START[1:0];
		send_beat(sb, 1'b0, '0);
		repeat (40) send_beat(rand_beat(KIND_TICK), 1'b0, '0);
		send_beat(rand_beat(KIND_CMD), 1'b0, '0);

		s_tvalid <= 1'b0;
		while (line_res_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && line_res_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	initial begin : result_side
		int        stall;
		line_res_t got;
		line_res_t want;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap(out_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got = m_tdata[13:0];
			if (line_res_q.size() == 0) begin
				$error("result beat %0h with no expectation waiting", got);
				err_cnt++;
			end else begin
				want = line_res_q.pop_front();
				check_field("scl_level", 8'(want.scl), 8'(got.scl));
				check_field("sda_level", 8'(want.sda), 8'(got.sda));
				check_field("busy_res", 8'(want.busy), 8'(got.busy));
				check_field("done_res", 8'(want.done), 8'(got.done));
				check_field("rx_byte", want.rx, got.rx);
				check_field("nack_seen", 8'(want.nack), 8'(got.nack));
				check_field("rejected", 8'(want.rej), 8'(got.rej));
			end
		end
	end

	// Stop the run if no beat moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
